[sv/fla_pkg.sv]
// shared types and constants for the free list index allocator
package fla_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 256;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned INDEX_W          = 8;
  localparam int unsigned LINK_W           = 8;
  localparam int unsigned STATUS_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT       = 3'd0,
    CMD_ALLOC      = 3'd1,
    CMD_FREE_ONE   = 3'd2,
    CMD_FREE_CHAIN = 3'd3,
    CMD_SET_LINK   = 3'd4,
    CMD_READ_LINK  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_LONG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_CH_RD,
    S_CH_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    status_e            status;
  } res_t;

endpackage

[sv/fla_core.sv]
// sequencer and link memory of the free list index allocator
module fla_core #(
  parameter int unsigned POOL_ENTRIES = fla_pkg::POOL_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fla_pkg::CMD_W-1:0]    cmd_i,
  input  logic [fla_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [fla_pkg::LINK_W-1:0]   link_value_i,
  output logic                         ready_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output fla_pkg::res_t                res_o
);

  localparam int unsigned IDX_W = $clog2(POOL_ENTRIES);
  localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);

  fla_pkg::state_e state_q, state_d;

  logic [fla_pkg::CMD_W-1:0]   cmd_q;
  logic [fla_pkg::INDEX_W-1:0] idx_q;
  logic [fla_pkg::LINK_W-1:0]  lnk_q;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [IDX_W-1:0]            cur_q, cur_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [IDX_W-1:0]            sweep_q, sweep_d;
  logic                        report_q, report_d;
  fla_pkg::res_t               res_q, res_d;

  logic [IDX_W-1:0] mem [POOL_ENTRIES];
  logic [IDX_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;

  logic             idx_ok;
  logic             lnk_ok;
  logic             cur_ok;
  logic [IDX_W-1:0] idx_a;
  logic             sweep_last;
  logic             chain_full;

  assign idx_a      = IDX_W'(idx_q);
  assign idx_ok     = (idx_q != '0) && (32'(idx_q) < 32'(POOL_ENTRIES));
  assign lnk_ok     = 32'(lnk_q) < 32'(POOL_ENTRIES);
  assign cur_ok     = 32'(cur_q) < 32'(POOL_ENTRIES);
  assign sweep_last = sweep_q == IDX_W'(POOL_ENTRIES - 1);
  assign chain_full = cnt_q == CNT_W'(POOL_ENTRIES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fla_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_d = report_q ? fla_pkg::S_DONE : fla_pkg::S_IDLE;
        end
      end
      fla_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = fla_pkg::S_EXEC;
        end
      end
      fla_pkg::S_EXEC: begin
        case (cmd_q)
          fla_pkg::CMD_INIT: state_d = fla_pkg::S_SWEEP;
          fla_pkg::CMD_ALLOC: begin
            state_d = (head_q == '0) ? fla_pkg::S_DONE : fla_pkg::S_RD_WAIT;
          end
          fla_pkg::CMD_FREE_CHAIN: begin
            state_d = (idx_q != '0 && idx_ok) ? fla_pkg::S_CH_RD : fla_pkg::S_DONE;
          end
          fla_pkg::CMD_READ_LINK: begin
            state_d = idx_ok ? fla_pkg::S_RD_WAIT : fla_pkg::S_DONE;
          end
          default: state_d = fla_pkg::S_DONE;
        endcase
      end
      fla_pkg::S_RD_WAIT: state_d = fla_pkg::S_DONE;
      fla_pkg::S_CH_RD: begin
        if (cur_q == '0 || chain_full || !cur_ok) begin
          state_d = fla_pkg::S_DONE;
        end else begin
          state_d = fla_pkg::S_CH_WAIT;
        end
      end
      fla_pkg::S_CH_WAIT: state_d = fla_pkg::S_CH_RD;
      fla_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = fla_pkg::S_IDLE;
        end
      end
      default: state_d = fla_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d   = head_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    sweep_d  = sweep_q;
    report_d = report_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_addr  = cur_q;
    wr_data  = head_q;
    rd_addr  = cur_q;
    ready_o     = state_q == fla_pkg::S_IDLE;
    res_valid_o = state_q == fla_pkg::S_DONE;
    case (state_q)
      fla_pkg::S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wr_data = (sweep_last || sweep_q == '0) ? '0 : sweep_q + IDX_W'(1);
        sweep_d = sweep_q + IDX_W'(1);
        if (sweep_last) begin
          head_d   = IDX_W'(1);
          report_d = 1'b0;
        end
      end
      fla_pkg::S_EXEC: begin
        res_d.status = fla_pkg::ST_OK;
        res_d.index  = '0;
        case (cmd_q)
          fla_pkg::CMD_INIT: begin
            sweep_d  = '0;
            report_d = 1'b1;
          end
          fla_pkg::CMD_ALLOC: begin
            rd_addr = head_q;
            if (head_q == '0) begin
              res_d.status = fla_pkg::ST_EMPTY;
            end
          end
          fla_pkg::CMD_FREE_ONE: begin
            if (!idx_ok) begin
              res_d.status = fla_pkg::ST_BAD;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx_a;
              wr_data = head_q;
              head_d  = idx_a;
            end
          end
          fla_pkg::CMD_FREE_CHAIN: begin
            if (idx_q != '0 && !idx_ok) begin
              res_d.status = fla_pkg::ST_BAD;
            end
            cur_d = idx_a;
            cnt_d = '0;
          end
          fla_pkg::CMD_SET_LINK: begin
            if (!idx_ok || !lnk_ok) begin
              res_d.status = fla_pkg::ST_BAD;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx_a;
              wr_data = IDX_W'(lnk_q);
            end
          end
          fla_pkg::CMD_READ_LINK: begin
            rd_addr = idx_a;
            if (!idx_ok) begin
              res_d.status = fla_pkg::ST_BAD;
            end
          end
          default: ;
        endcase
      end
      fla_pkg::S_RD_WAIT: begin
        if (cmd_q == fla_pkg::CMD_ALLOC) begin
          head_d      = rd_data_q;
          res_d.index = fla_pkg::INDEX_W'(head_q);
        end else begin
          res_d.index = fla_pkg::INDEX_W'(rd_data_q);
        end
      end
      fla_pkg::S_CH_RD: begin
        // zero link ends the walk, then the step limit, then range
        rd_addr = cur_q;
        if (cur_q != '0) begin
          if (chain_full) begin
            res_d.status = fla_pkg::ST_LONG;
          end else if (!cur_ok) begin
            res_d.status = fla_pkg::ST_BAD;
          end
        end
      end
      fla_pkg::S_CH_WAIT: begin
        // push the current entry, follow its old link
        wr_en   = 1'b1;
        wr_addr = cur_q;
        wr_data = head_q;
        head_d  = cur_q;
        cur_d   = rd_data_q;
        cnt_d   = cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fla_pkg::S_SWEEP;
      head_q   <= IDX_W'(1);
      report_q <= 1'b0;
      sweep_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      report_q <= report_d;
      sweep_q  <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == fla_pkg::S_IDLE) begin
      cmd_q <= cmd_i;
      idx_q <= entry_index_i;
      lnk_q <= link_value_i;
    end
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[sv/free_list_index_allocator.sv]
// commands: init sweeps the link memory one entry per cycle; free_chain walks the chain,
//   reading each entry's link and then pushing that entry onto the free list
// throughput: one command at a time through the link memory (one write and one read port) and sequencer,
//   next command taken the cycle after its result enters the output register
// reset: a sweep over all POOL_ENTRIES entries rebuilds the link chain before the first transfer
// top level: command stream in, status and index stream out
module free_list_index_allocator #(
  parameter int unsigned POOL_ENTRIES = fla_pkg::POOL_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cmd[2:0], entry_index[10:3], link_value[18:11], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], index_out[9:2]
);

  logic          core_ready;
  logic          start;
  logic          res_valid;
  logic          res_ready;
  fla_pkg::res_t res;

  logic          out_valid_q, out_valid_d;
  fla_pkg::res_t out_q;

  assign s_axis_tready = core_ready;
  assign start         = s_axis_tvalid & core_ready;

  fla_core #(
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_i        (s_axis_tdata[2:0]),
    .entry_index_i(s_axis_tdata[10:3]),
    .link_value_i (s_axis_tdata[18:11]),
    .ready_o      (core_ready),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register frees up in the same cycle it is drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule
